@@ rtl/tlsf_pkg.sv @@
// Shared constants, types and class-mapping functions of the TLSF block allocator.
package tlsf_pkg;

   localparam int POOL_BYTES    = 8192;
   localparam int GRANULE_BYTES = 16;
   localparam int HEADER_BYTES  = 40;
   localparam int FL_COUNT      = 14;
   localparam int SL_COUNT      = 32;

   localparam int BLOCKS       = POOL_BYTES / GRANULE_BYTES;
   localparam int BLK_W        = $clog2(BLOCKS);
   localparam int SIZE_W       = $clog2(BLOCKS + 1);
   localparam int SL_LOG2      = $clog2(SL_COUNT);
   localparam int FL_W         = $clog2(FL_COUNT);
   localparam int CLASSES      = FL_COUNT * SL_COUNT;
   localparam int CLS_W        = FL_W + SL_LOG2;
   localparam int MIN_GRANULES = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
   localparam int GRAN_SHIFT   = $clog2(GRANULE_BYTES);
   localparam int BYTE_W       = $clog2(POOL_BYTES) + 2;
   localparam int ADDR_W       = 13;
   localparam int REQ_W        = 14;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_BAD   = 2'd1,
      STAT_NOMEM = 2'd2
   } status_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [BLK_W-1:0]  prev_phys;
      logic [BLK_W-1:0]  link_next;
      logic [BLK_W-1:0]  link_prev;
      logic              start;
      logic              is_free;
      logic              has_next;
      logic              has_prev;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [FL_W-1:0]    fl;
      logic [SL_LOG2-1:0] sl;
   } class_type;

   typedef struct packed {
      logic               set_en;
      logic               clr_en;
      logic [SL_LOG2-1:0] sl;
   } map_op_type;

   function automatic class_type map_class(input logic [BYTE_W-1:0] bytes);
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] sh;
      logic [4:0]        m;
      class_type         c;
      b = (bytes == '0) ? BYTE_W'(1) : bytes;
      m = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         if (b[i]) m = 5'(i);
      end
      if (m >= 5'(SL_LOG2)) sh = b >> (m - 5'(SL_LOG2));
      else sh = b << (5'(SL_LOG2) - m);
      c.sl = sh[SL_LOG2-1:0];
      c.fl = m[FL_W-1:0];
      if (m >= 5'(FL_COUNT)) begin
         c.fl = FL_W'(FL_COUNT - 1);
         c.sl = '1;
      end
      return c;
   endfunction

   function automatic logic [SL_LOG2-1:0] lowest_sl(input logic [SL_COUNT-1:0] v);
      logic [SL_LOG2-1:0] r;
      r = '0;
      for (int i = SL_COUNT - 1; i >= 0; i--) begin
         if (v[i]) r = SL_LOG2'(i);
      end
      return r;
   endfunction

   function automatic logic [FL_W-1:0] lowest_fl(input logic [FL_COUNT-1:0] v);
      logic [FL_W-1:0] r;
      r = '0;
      for (int i = FL_COUNT - 1; i >= 0; i--) begin
         if (v[i]) r = FL_W'(i);
      end
      return r;
   endfunction

   localparam class_type POOL_CLASS = map_class(BYTE_W'(POOL_BYTES));

endpackage

@@ rtl/tlsf_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module tlsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tlsf_bitmaps.sv @@
// First- and second-level occupancy bitmaps of the TLSF class lists.
module tlsf_bitmaps (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [tlsf_pkg::FL_W-1:0]    row_fl,
   input  tlsf_pkg::map_op_type         map_op,
   output logic [tlsf_pkg::SL_COUNT-1:0] row,
   output logic [tlsf_pkg::FL_COUNT-1:0] fl_map
);

   logic [tlsf_pkg::SL_COUNT-1:0] sl_map_ff [tlsf_pkg::FL_COUNT];
   logic [tlsf_pkg::SL_COUNT-1:0] sl_map_in [tlsf_pkg::FL_COUNT];
   logic [tlsf_pkg::FL_COUNT-1:0] fl_map_ff;
   logic [tlsf_pkg::FL_COUNT-1:0] fl_map_in;
   logic [tlsf_pkg::FL_COUNT-1:0] row_nz;

   assign row    = sl_map_ff[row_fl];
   assign fl_map = fl_map_ff;

   always_comb begin
      logic [tlsf_pkg::SL_COUNT-1:0] r;
      sl_map_in = sl_map_ff;
      fl_map_in = fl_map_ff;
      r = sl_map_ff[row_fl];
      if (map_op.set_en) begin
         r[map_op.sl]      = 1'b1;
         sl_map_in[row_fl] = r;
         fl_map_in[row_fl] = 1'b1;
      end else if (map_op.clr_en) begin
         r[map_op.sl]      = 1'b0;
         sl_map_in[row_fl] = r;
         if (r == '0) fl_map_in[row_fl] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tlsf_pkg::FL_COUNT; i++) sl_map_ff[i] <= '0;
         sl_map_ff[tlsf_pkg::POOL_CLASS.fl] <=
            tlsf_pkg::SL_COUNT'(1) << tlsf_pkg::POOL_CLASS.sl;
         fl_map_ff <= tlsf_pkg::FL_COUNT'(1) << tlsf_pkg::POOL_CLASS.fl;
      end else begin
         sl_map_ff <= sl_map_in;
         fl_map_ff <= fl_map_in;
      end
   end

   always_comb begin
      for (int i = 0; i < tlsf_pkg::FL_COUNT; i++) row_nz[i] = |sl_map_ff[i];
   end

   a_fl_tracks_rows: assert property (@(posedge clock) disable iff (reset)
      fl_map_ff == row_nz)
      else $error("first-level map out of step with second-level rows");

endmodule

@@ rtl/tlsf_block_allocator_core.sv @@
// TLSF block allocator top level: request sequencer over the block table and list-head RAMs.
// Allocates and frees blocks of an 8 KiB pool in 16-byte granules with a 40-byte header.
// One request is worked at a time; each takes a sequence of steps on the
// block-table RAM (one read or one read-modify-write per neighbor touched) plus the
// list-head RAM. A free merges with free neighbors on both sides. The result sits in
// an output register, so the next request is taken while it waits. After reset the
// block writes the initial whole-pool entry with the request side stalled.
module tlsf_block_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [tlsf_pkg::REQ_W-1:0]    req_request_size,
   input  logic [tlsf_pkg::ADDR_W-1:0]   req_block_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tlsf_pkg::ADDR_W-1:0]   rsp_address,
   output logic [1:0]                    rsp_status
);

   typedef enum logic [25:0] {
      ST_INIT  = 26'd1 << 0,
      ST_IDLE  = 26'd1 << 1,
      ST_A1    = 26'd1 << 2,
      ST_A2    = 26'd1 << 3,
      ST_A3    = 26'd1 << 4,
      ST_A4    = 26'd1 << 5,
      ST_A5    = 26'd1 << 6,
      ST_A6    = 26'd1 << 7,
      ST_SPLIT = 26'd1 << 8,
      ST_F1    = 26'd1 << 9,
      ST_F2    = 26'd1 << 10,
      ST_F3    = 26'd1 << 11,
      ST_F4    = 26'd1 << 12,
      ST_F5    = 26'd1 << 13,
      ST_F6    = 26'd1 << 14,
      ST_U0    = 26'd1 << 15,
      ST_U1    = 26'd1 << 16,
      ST_U2    = 26'd1 << 17,
      ST_U3    = 26'd1 << 18,
      ST_N0    = 26'd1 << 19,
      ST_N1    = 26'd1 << 20,
      ST_L0    = 26'd1 << 21,
      ST_L1    = 26'd1 << 22,
      ST_L2    = 26'd1 << 23,
      ST_L3    = 26'd1 << 24,
      ST_DONE  = 26'd1 << 25
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [tlsf_pkg::SIZE_W-1:0] need_ff, need_in;
   tlsf_pkg::class_type         cls_ff, cls_in;
   tlsf_pkg::entry_type         cur_ff, cur_in, vic_ff, vic_in;
   logic [tlsf_pkg::BLK_W-1:0]  cur_idx_ff, cur_idx_in, vic_idx_ff, vic_idx_in;
   logic [tlsf_pkg::BLK_W-1:0]  head_ff, head_in;
   logic                        link_valid_ff, link_valid_in;
   logic [tlsf_pkg::ADDR_W-1:0] res_addr_ff, res_addr_in;
   tlsf_pkg::status_type        res_status_ff, res_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tlsf_pkg::ADDR_W-1:0] rsp_address_ff, rsp_address_in;
   tlsf_pkg::status_type        rsp_status_ff, rsp_status_in;

   logic                          blk_we;
   logic [tlsf_pkg::BLK_W-1:0]    blk_waddr, blk_raddr;
   tlsf_pkg::entry_type           blk_wdata, blk_rd;
   logic [tlsf_pkg::ENTRY_W-1:0]  blk_rdata;
   logic                          hd_we;
   logic [tlsf_pkg::CLS_W-1:0]    hd_waddr, hd_raddr;
   logic [tlsf_pkg::BLK_W-1:0]    hd_wdata, hd_rdata;

   logic [tlsf_pkg::FL_W-1:0]     row_fl;
   tlsf_pkg::map_op_type          map_op;
   logic [tlsf_pkg::SL_COUNT-1:0] row;
   logic [tlsf_pkg::FL_COUNT-1:0] fl_map;

   tlsf_ram #(
      .WIDTH(tlsf_pkg::ENTRY_W),
      .DEPTH(tlsf_pkg::BLOCKS)
   ) u_block_table (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_addr (blk_waddr),
      .wr_data (blk_wdata),
      .rd_addr (blk_raddr),
      .rd_data (blk_rdata)
   );

   tlsf_ram #(
      .WIDTH(tlsf_pkg::BLK_W),
      .DEPTH(tlsf_pkg::CLASSES)
   ) u_list_heads (
      .clock   (clock),
      .wr_en   (hd_we),
      .wr_addr (hd_waddr),
      .wr_data (hd_wdata),
      .rd_addr (hd_raddr),
      .rd_data (hd_rdata)
   );

   tlsf_bitmaps u_bitmaps (
      .clock  (clock),
      .reset  (reset),
      .row_fl (row_fl),
      .map_op (map_op),
      .row    (row),
      .fl_map (fl_map)
   );

   assign blk_rd      = tlsf_pkg::entry_type'(blk_rdata);
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

   always_comb begin
      tlsf_pkg::class_type                      c;
      tlsf_pkg::entry_type                      ent;
      logic [tlsf_pkg::BYTE_W-1:0]              bytes_v;
      logic [tlsf_pkg::SIZE_W:0]                nsum;
      logic [tlsf_pkg::SL_COUNT-1:0]            masked;
      logic [tlsf_pkg::FL_COUNT-1:0]            flm;
      logic [tlsf_pkg::REQ_W:0]                 need_sum;
      logic [tlsf_pkg::REQ_W-tlsf_pkg::GRAN_SHIFT:0] need_g;
      logic [tlsf_pkg::ADDR_W-1:0]              a2;
      logic [tlsf_pkg::SIZE_W-1:0]              rem;

      state_in       = state_ff;
      ret_in         = ret_ff;
      need_in        = need_ff;
      cls_in         = cls_ff;
      cur_in         = cur_ff;
      vic_in         = vic_ff;
      cur_idx_in     = cur_idx_ff;
      vic_idx_in     = vic_idx_ff;
      head_in        = head_ff;
      link_valid_in  = link_valid_ff;
      res_addr_in    = res_addr_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;

      blk_we    = 1'b0;
      blk_waddr = '0;
      blk_wdata = '0;
      blk_raddr = '0;
      hd_we     = 1'b0;
      hd_waddr  = '0;
      hd_wdata  = '0;
      hd_raddr  = '0;
      row_fl    = cls_ff.fl;
      map_op    = '0;

      c        = '0;
      ent      = '0;
      bytes_v  = '0;
      nsum     = '0;
      masked   = '0;
      flm      = '0;
      need_sum = '0;
      need_g   = '0;
      a2       = '0;
      rem      = '0;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            ent         = '0;
            ent.size    = tlsf_pkg::SIZE_W'(tlsf_pkg::BLOCKS);
            ent.start   = 1'b1;
            ent.is_free = 1'b1;
            blk_we      = 1'b1;
            blk_waddr   = '0;
            blk_wdata   = ent;
            hd_we       = 1'b1;
            hd_waddr    = tlsf_pkg::POOL_CLASS;
            hd_wdata    = '0;
            state_in    = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_addr_in   = '0;
               res_status_in = tlsf_pkg::STAT_DONE;
               if (req_command == tlsf_pkg::CMD_ALLOC) begin
                  need_sum = {1'b0, req_request_size}
                           + (tlsf_pkg::REQ_W+1)'(tlsf_pkg::HEADER_BYTES
                                                 + tlsf_pkg::GRANULE_BYTES - 1);
                  need_g = need_sum[tlsf_pkg::REQ_W:tlsf_pkg::GRAN_SHIFT];
                  if (need_g < $bits(need_g)'(tlsf_pkg::MIN_GRANULES))
                     need_g = $bits(need_g)'(tlsf_pkg::MIN_GRANULES);
                  if (req_request_size == '0) begin
                     res_status_in = tlsf_pkg::STAT_BAD;
                     state_in      = ST_DONE;
                  end else if (need_g > $bits(need_g)'(tlsf_pkg::BLOCKS)) begin
                     res_status_in = tlsf_pkg::STAT_NOMEM;
                     state_in      = ST_DONE;
                  end else begin
                     need_in  = tlsf_pkg::SIZE_W'(need_g);
                     bytes_v  = tlsf_pkg::BYTE_W'(need_g) << tlsf_pkg::GRAN_SHIFT;
                     cls_in   = tlsf_pkg::map_class(bytes_v);
                     state_in = ST_A1;
                  end
               end else begin
                  a2 = req_block_address - tlsf_pkg::ADDR_W'(tlsf_pkg::HEADER_BYTES);
                  if (req_block_address < tlsf_pkg::ADDR_W'(tlsf_pkg::HEADER_BYTES) ||
                      a2[tlsf_pkg::GRAN_SHIFT-1:0] != '0) begin
                     res_status_in = tlsf_pkg::STAT_BAD;
                     state_in      = ST_DONE;
                  end else begin
                     blk_raddr  = tlsf_pkg::BLK_W'(a2 >> tlsf_pkg::GRAN_SHIFT);
                     cur_idx_in = tlsf_pkg::BLK_W'(a2 >> tlsf_pkg::GRAN_SHIFT);
                     state_in   = ST_F1;
                  end
               end
            end
         end
         ST_A1: begin
            // round the size up so every block of the class fits
            if (cls_ff.fl >= tlsf_pkg::FL_W'(tlsf_pkg::SL_LOG2) &&
                ({1'b0, cls_ff.fl} + 1'b1) < (tlsf_pkg::FL_W+1)'(tlsf_pkg::FL_COUNT)) begin
               bytes_v = (tlsf_pkg::BYTE_W'(need_ff) << tlsf_pkg::GRAN_SHIFT)
                       + ((tlsf_pkg::BYTE_W'(1)
                           << (cls_ff.fl - tlsf_pkg::FL_W'(tlsf_pkg::SL_LOG2)))
                          - tlsf_pkg::BYTE_W'(1));
               cls_in = tlsf_pkg::map_class(bytes_v);
            end
            state_in = ST_A2;
         end
         ST_A2: begin
            masked = row & ({tlsf_pkg::SL_COUNT{1'b1}} << cls_ff.sl);
            flm    = fl_map & ({tlsf_pkg::FL_COUNT{1'b1}} << ({1'b0, cls_ff.fl} + 1'b1));
            if (masked != '0) begin
               cls_in.sl = tlsf_pkg::lowest_sl(masked);
               state_in  = ST_A4;
            end else if (flm == '0) begin
               res_status_in = tlsf_pkg::STAT_NOMEM;
               state_in      = ST_DONE;
            end else begin
               cls_in.fl = tlsf_pkg::lowest_fl(flm);
               state_in  = ST_A3;
            end
         end
         ST_A3: begin
            cls_in.sl = tlsf_pkg::lowest_sl(row);
            state_in  = ST_A4;
         end
         ST_A4: begin
            hd_raddr = cls_ff;
            state_in = ST_A5;
         end
         ST_A5: begin
            blk_raddr  = hd_rdata;
            vic_idx_in = hd_rdata;
            state_in   = ST_A6;
         end
         ST_A6: begin
            vic_in = blk_rd;
            if (blk_rd.size < need_ff) begin
               res_status_in = tlsf_pkg::STAT_NOMEM;
               state_in      = ST_DONE;
            end else begin
               ret_in   = ST_SPLIT;
               state_in = ST_U0;
            end
         end
         ST_SPLIT: begin
            rem         = vic_ff.size - need_ff;
            res_addr_in = (tlsf_pkg::ADDR_W'(vic_idx_ff) << tlsf_pkg::GRAN_SHIFT)
                        + tlsf_pkg::ADDR_W'(tlsf_pkg::HEADER_BYTES);
            blk_we    = 1'b1;
            blk_waddr = vic_idx_ff;
            ent       = vic_ff;
            if (rem >= tlsf_pkg::SIZE_W'(tlsf_pkg::MIN_GRANULES)) begin
               ent.size         = need_ff;
               cur_in           = '0;
               cur_in.size      = rem;
               cur_in.prev_phys = vic_idx_ff;
               cur_in.start     = 1'b1;
               cur_idx_in       = vic_idx_ff + tlsf_pkg::BLK_W'(need_ff);
               state_in         = ST_N0;
            end else begin
               state_in = ST_DONE;
            end
            blk_wdata = ent;
         end
         ST_F1: begin
            cur_in = blk_rd;
            if (!blk_rd.start || blk_rd.is_free) begin
               res_status_in = tlsf_pkg::STAT_BAD;
               state_in      = ST_DONE;
            end else if (cur_idx_ff != '0) begin
               blk_raddr  = blk_rd.prev_phys;
               vic_idx_in = blk_rd.prev_phys;
               state_in   = ST_F2;
            end else begin
               state_in = ST_F4;
            end
         end
         ST_F2: begin
            vic_in = blk_rd;
            if (blk_rd.is_free) begin
               ret_in   = ST_F3;
               state_in = ST_U0;
            end else begin
               state_in = ST_F4;
            end
         end
         ST_F3: begin
            ent        = cur_ff;
            ent.start  = 1'b0;
            blk_we     = 1'b1;
            blk_waddr  = cur_idx_ff;
            blk_wdata  = ent;
            cur_in     = vic_ff;
            cur_in.size = vic_ff.size + cur_ff.size;
            cur_idx_in = vic_idx_ff;
            state_in   = ST_F4;
         end
         ST_F4: begin
            nsum = {1'b0, tlsf_pkg::SIZE_W'(cur_idx_ff)} + {1'b0, cur_ff.size};
            if (nsum < (tlsf_pkg::SIZE_W+1)'(tlsf_pkg::BLOCKS)) begin
               blk_raddr  = nsum[tlsf_pkg::BLK_W-1:0];
               vic_idx_in = nsum[tlsf_pkg::BLK_W-1:0];
               state_in   = ST_F5;
            end else begin
               state_in = ST_N0;
            end
         end
         ST_F5: begin
            vic_in = blk_rd;
            if (blk_rd.is_free) begin
               ret_in   = ST_F6;
               state_in = ST_U0;
            end else begin
               state_in = ST_N0;
            end
         end
         ST_F6: begin
            cur_in.size = cur_ff.size + vic_ff.size;
            ent         = vic_ff;
            ent.start   = 1'b0;
            blk_we      = 1'b1;
            blk_waddr   = vic_idx_ff;
            blk_wdata   = ent;
            state_in    = ST_N0;
         end
         ST_U0: begin
            bytes_v = tlsf_pkg::BYTE_W'(vic_ff.size) << tlsf_pkg::GRAN_SHIFT;
            c       = tlsf_pkg::map_class(bytes_v);
            cls_in  = c;
            row_fl  = c.fl;
            if (vic_ff.has_prev) begin
               blk_raddr = vic_ff.link_prev;
               state_in  = ST_U1;
            end else begin
               hd_we    = 1'b1;
               hd_waddr = c;
               hd_wdata = vic_ff.link_next;
               if (!vic_ff.has_next) begin
                  map_op.clr_en = 1'b1;
                  map_op.sl     = c.sl;
               end
               state_in = ST_U2;
            end
         end
         ST_U1: begin
            ent          = blk_rd;
            ent.link_next = vic_ff.link_next;
            ent.has_next = vic_ff.has_next;
            blk_we       = 1'b1;
            blk_waddr    = vic_ff.link_prev;
            blk_wdata    = ent;
            state_in     = ST_U2;
         end
         ST_U2: begin
            if (vic_ff.has_next) begin
               blk_raddr = vic_ff.link_next;
               state_in  = ST_U3;
            end else begin
               vic_in.is_free  = 1'b0;
               vic_in.has_next = 1'b0;
               vic_in.has_prev = 1'b0;
               state_in        = ret_ff;
            end
         end
         ST_U3: begin
            ent           = blk_rd;
            ent.link_prev = vic_ff.link_prev;
            ent.has_prev  = vic_ff.has_prev;
            blk_we        = 1'b1;
            blk_waddr     = vic_ff.link_next;
            blk_wdata     = ent;
            vic_in.is_free  = 1'b0;
            vic_in.has_next = 1'b0;
            vic_in.has_prev = 1'b0;
            state_in        = ret_ff;
         end
         ST_N0: begin
            nsum = {1'b0, tlsf_pkg::SIZE_W'(cur_idx_ff)} + {1'b0, cur_ff.size};
            if (nsum < (tlsf_pkg::SIZE_W+1)'(tlsf_pkg::BLOCKS)) begin
               blk_raddr = nsum[tlsf_pkg::BLK_W-1:0];
               state_in  = ST_N1;
            end else begin
               state_in = ST_L0;
            end
         end
         ST_N1: begin
            nsum = {1'b0, tlsf_pkg::SIZE_W'(cur_idx_ff)} + {1'b0, cur_ff.size};
            ent           = blk_rd;
            ent.prev_phys = cur_idx_ff;
            blk_we        = 1'b1;
            blk_waddr     = nsum[tlsf_pkg::BLK_W-1:0];
            blk_wdata     = ent;
            state_in      = ST_L0;
         end
         ST_L0: begin
            bytes_v       = tlsf_pkg::BYTE_W'(cur_ff.size) << tlsf_pkg::GRAN_SHIFT;
            c             = tlsf_pkg::map_class(bytes_v);
            cls_in        = c;
            row_fl        = c.fl;
            link_valid_in = row[c.sl];
            if (row[c.sl]) begin
               hd_raddr = c;
               state_in = ST_L1;
            end else begin
               state_in = ST_L3;
            end
         end
         ST_L1: begin
            head_in   = hd_rdata;
            blk_raddr = hd_rdata;
            state_in  = ST_L2;
         end
         ST_L2: begin
            ent           = blk_rd;
            ent.link_prev = cur_idx_ff;
            ent.has_prev  = 1'b1;
            blk_we        = 1'b1;
            blk_waddr     = head_ff;
            blk_wdata     = ent;
            state_in      = ST_L3;
         end
         ST_L3: begin
            ent           = cur_ff;
            ent.is_free   = 1'b1;
            ent.has_prev  = 1'b0;
            ent.has_next  = link_valid_ff;
            ent.link_next = head_ff;
            blk_we        = 1'b1;
            blk_waddr     = cur_idx_ff;
            blk_wdata     = ent;
            hd_we         = 1'b1;
            hd_waddr      = cls_ff;
            hd_wdata      = cur_idx_ff;
            map_op.set_en = 1'b1;
            map_op.sl     = cls_ff.sl;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_address_in = res_addr_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff        <= need_in;
      cls_ff         <= cls_in;
      cur_ff         <= cur_in;
      vic_ff         <= vic_in;
      cur_idx_ff     <= cur_idx_in;
      vic_idx_ff     <= vic_idx_in;
      head_ff        <= head_in;
      link_valid_ff  <= link_valid_in;
      res_addr_ff    <= res_addr_in;
      res_status_ff  <= res_status_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
   end

   a_fail_no_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != tlsf_pkg::STAT_DONE |-> rsp_address == '0)
      else $error("failed request carries a nonzero address");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("accepted request did not start");

   a_unlink_free_only: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_U0 |-> vic_ff.is_free)
      else $error("unlink of a block that is not free");

endmodule
